// ===== rtl/lqpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqpi_pkg
// Shared types, codes and arithmetic helpers for the luma quarter-pel
// interpolator.
// ----------------------------------------------------------------------------
package lqpi_pkg;

    typedef logic [7:0] t_pix;

    // six by six neighbourhood, [row][column], row 0 is the oldest line
    typedef logic [5:0][5:0][7:0] t_window;

    // one word in the queue between the window front and the filter back
    typedef struct packed {
        t_window win;
        logic    last;
    } t_qword;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAC_X       = 2'd0;
    localparam logic [1:0] CFG_FRAC_Y       = 2'd1;
    localparam logic [1:0] CFG_BLOCK_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_BLOCK_HEIGHT = 2'd3;

    // quarter-pel positions, code is {frac_y, frac_x}
    typedef enum logic [3:0] {
        QP_G, QP_A, QP_B, QP_C,
        QP_D, QP_E, QP_F, QP_G2,
        QP_H, QP_I, QP_J, QP_K,
        QP_N, QP_P, QP_Q, QP_R
    } t_qpos;

    // six-tap filter 1,-5,20,20,-5,1 on sign-extended 22-bit operands
    function automatic logic signed [21:0] tap6(
        input logic signed [21:0] p0, input logic signed [21:0] p1,
        input logic signed [21:0] p2, input logic signed [21:0] p3,
        input logic signed [21:0] p4, input logic signed [21:0] p5);
        logic signed [21:0] s23;
        logic signed [21:0] s14;
        s23 = p2 + p3;
        s14 = p1 + p4;
        return p0 + p5 + (s23 <<< 4) + (s23 <<< 2) - (s14 <<< 2) - s14;
    endfunction

    // round with +16 >> 5, clip to 0..255
    function automatic t_pix round_clip5(input logic signed [21:0] v);
        logic signed [21:0] t;
        logic signed [21:0] r;
        t = v + 22'sd16;
        r = t >>> 5;
        if (t < 0) begin
            return 8'd0;
        end else if (r > 22'sd255) begin
            return 8'd255;
        end
        return r[7:0];
    endfunction

    // round with +512 >> 10, clip to 0..255
    function automatic t_pix round_clip10(input logic signed [21:0] v);
        logic signed [21:0] t;
        logic signed [21:0] r;
        t = v + 22'sd512;
        r = t >>> 10;
        if (t < 0) begin
            return 8'd0;
        end else if (r > 22'sd255) begin
            return 8'd255;
        end
        return r[7:0];
    endfunction

    // rounded-up average of two pixels
    function automatic t_pix avg_up(input t_pix a, input t_pix b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

endpackage

// ===== rtl/lqpi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lqpi_front
// Accepts window pixels, tracks the window position, keeps five line stores
// and the six by six window, and pushes a window word for each output pixel.
// ----------------------------------------------------------------------------
module lqpi_front #(
    parameter int MAX_BLOCK_WIDTH  = 16,
    parameter int MAX_BLOCK_HEIGHT = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [7:0]       i_ref_pixel,
    input  wire logic             i_restart,
    input  wire logic [4:0]       i_block_width,
    input  wire logic [4:0]       i_block_height,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output lqpi_pkg::t_qword      o_q_word
);

    localparam int LINE_LEN = MAX_BLOCK_WIDTH + 5;
    localparam int CW       = $clog2(MAX_BLOCK_WIDTH + 5);
    localparam int RW       = $clog2(MAX_BLOCK_HEIGHT + 5);

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [2:0]    r_slot;
    logic [6:0]    w_eff;
    logic [6:0]    h_eff;
    logic          col_last;
    logic          row_last;
    logic          accept;

    logic          r_b_valid;
    logic          r_b_emit;
    logic          r_b_last;
    logic [2:0]    r_b_slot;
    logic [7:0]    r_b_pix;
    logic [7:0]    r_rd [5];
    logic          b_go;
    logic          b_adv;

    lqpi_pkg::t_window r_win;
    lqpi_pkg::t_window n_win;

    // clamp the block size to 1..max
    always_comb begin
        if (i_block_width == 5'd0) begin
            w_eff = 7'd1;
        end else if ({2'b00, i_block_width} > 7'(MAX_BLOCK_WIDTH)) begin
            w_eff = 7'(MAX_BLOCK_WIDTH);
        end else begin
            w_eff = {2'b00, i_block_width};
        end
        if (i_block_height == 5'd0) begin
            h_eff = 7'd1;
        end else if ({2'b00, i_block_height} > 7'(MAX_BLOCK_HEIGHT)) begin
            h_eff = 7'(MAX_BLOCK_HEIGHT);
        end else begin
            h_eff = {2'b00, i_block_height};
        end
    end

    assign col_last = (7'(r_col) == w_eff + 7'd4);
    assign row_last = (7'(r_row) == h_eff + 7'd4);

    // stage B moves on unless it holds an output word and the queue is full
    assign b_go    = !r_b_emit || !i_q_full;
    assign b_adv   = r_b_valid && b_go;
    assign o_stall = r_b_valid && !b_go;
    assign accept  = i_valid && !o_stall;

    // advance the window position; a register write restarts the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= 3'd0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    r_row  <= '0;
                    r_slot <= 3'd0;
                end else begin
                    r_row  <= r_row + 1'b1;
                    r_slot <= (r_slot == 3'd4) ? 3'd0 : r_slot + 3'd1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // line stores: one memory per slot, read all at the column, write one
    for (genvar g = 0; g < 5; g++) begin : g_line
        logic [7:0] r_mem [LINE_LEN];
        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_rd[g] <= r_mem[r_col];
                if (r_slot == 3'(g)) begin
                    r_mem[r_col] <= i_ref_pixel;
                end
            end
        end
    end

    // stage B control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept || (r_b_valid && !b_go);
        end
    end

    // stage B payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix  <= i_ref_pixel;
            r_b_slot <= r_slot;
            r_b_emit <= (7'(r_col) >= 7'd5) && (7'(r_row) >= 7'd5);
            r_b_last <= col_last && row_last;
        end
    end

    // shift the window left and bring in the new column
    always_comb begin
        logic [3:0] idx;
        for (int k = 0; k < 6; k++) begin
            for (int c = 0; c < 5; c++) begin
                n_win[k][c] = r_win[k][c+1];
            end
        end
        for (int k = 0; k < 5; k++) begin
            idx = {1'b0, r_b_slot} + 4'(k);
            if (idx >= 4'd5) begin
                idx = idx - 4'd5;
            end
            n_win[k][5] = r_rd[idx[2:0]];
        end
        n_win[5][5] = r_b_pix;
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_win <= n_win;
        end
    end

    assign o_q_push      = b_adv && r_b_emit;
    assign o_q_word.win  = n_win;
    assign o_q_word.last = r_b_last;

endmodule
`default_nettype wire

// ===== rtl/lqpi_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lqpi_queue
// Two-entry queue of window words between the front and the filter back.
// ----------------------------------------------------------------------------
module lqpi_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lqpi_pkg::t_qword i_word,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output lqpi_pkg::t_qword      o_word
);

    lqpi_pkg::t_qword r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_word  = r_mem[r_rp];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // store the word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lqpi_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lqpi_back
// Three-stage filter: six-tap sums, half-pel rounding and the centre sample,
// then quarter-pel selection into the output register.
// ----------------------------------------------------------------------------
module lqpi_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_frac_x,
    input  wire logic [1:0]       i_frac_y,
    input  wire logic             i_q_empty,
    input  wire lqpi_pkg::t_qword i_q_word,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [7:0]            o_pred_pixel,
    output logic                  o_block_end
);

    logic en;

    logic                      r_s1_valid;
    logic signed [14:0]        r_s1_row [2];
    logic signed [14:0]        r_s1_col [6];
    logic [7:0]                r_s1_g;
    logic [7:0]                r_s1_h;
    logic [7:0]                r_s1_m;
    logic                      r_s1_last;

    logic                      r_s2_valid;
    logic [7:0]                r_s2_b;
    logic [7:0]                r_s2_s;
    logic [7:0]                r_s2_hh;
    logic [7:0]                r_s2_mm;
    logic [7:0]                r_s2_j;
    logic [7:0]                r_s2_g;
    logic [7:0]                r_s2_h;
    logic [7:0]                r_s2_m;
    logic                      r_s2_last;

    logic                      r_o_valid;
    logic [7:0]                r_o_pix;
    logic                      r_o_last;
    logic [7:0]                n_o_pix;

    lqpi_pkg::t_window         win;
    lqpi_pkg::t_qpos           pos;

    // whole pipeline moves when the output register is free
    assign en      = !r_o_valid || !i_stall;
    assign o_q_pop = en && !i_q_empty;
    assign win     = i_q_word.win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            r_s1_valid <= !i_q_empty;
            r_s2_valid <= r_s1_valid;
            r_o_valid  <= r_s2_valid;
        end
    end

    // stage 1: row and column six-tap sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 2; r++) begin
                r_s1_row[r] <= 15'(lqpi_pkg::tap6(
                    22'(win[r+2][0]), 22'(win[r+2][1]), 22'(win[r+2][2]),
                    22'(win[r+2][3]), 22'(win[r+2][4]), 22'(win[r+2][5])));
            end
            for (int c = 0; c < 6; c++) begin
                r_s1_col[c] <= 15'(lqpi_pkg::tap6(
                    22'(win[0][c]), 22'(win[1][c]), 22'(win[2][c]),
                    22'(win[3][c]), 22'(win[4][c]), 22'(win[5][c])));
            end
            r_s1_g    <= win[2][2];
            r_s1_h    <= win[2][3];
            r_s1_m    <= win[3][2];
            r_s1_last <= i_q_word.last;
        end
    end

    // stage 2: half-pel samples and the centre sample
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_b  <= lqpi_pkg::round_clip5(22'(r_s1_row[0]));
            r_s2_s  <= lqpi_pkg::round_clip5(22'(r_s1_row[1]));
            r_s2_hh <= lqpi_pkg::round_clip5(22'(r_s1_col[2]));
            r_s2_mm <= lqpi_pkg::round_clip5(22'(r_s1_col[3]));
            r_s2_j  <= lqpi_pkg::round_clip10(lqpi_pkg::tap6(
                22'(r_s1_col[0]), 22'(r_s1_col[1]), 22'(r_s1_col[2]),
                22'(r_s1_col[3]), 22'(r_s1_col[4]), 22'(r_s1_col[5])));
            r_s2_g    <= r_s1_g;
            r_s2_h    <= r_s1_h;
            r_s2_m    <= r_s1_m;
            r_s2_last <= r_s1_last;
        end
    end

    // stage 3: pick the quarter-pel position
    assign pos = lqpi_pkg::t_qpos'({i_frac_y, i_frac_x});

    always_comb begin
        unique case (pos)
            lqpi_pkg::QP_G:  n_o_pix = r_s2_g;
            lqpi_pkg::QP_A:  n_o_pix = lqpi_pkg::avg_up(r_s2_g, r_s2_b);
            lqpi_pkg::QP_B:  n_o_pix = r_s2_b;
            lqpi_pkg::QP_C:  n_o_pix = lqpi_pkg::avg_up(r_s2_h, r_s2_b);
            lqpi_pkg::QP_D:  n_o_pix = lqpi_pkg::avg_up(r_s2_g, r_s2_hh);
            lqpi_pkg::QP_E:  n_o_pix = lqpi_pkg::avg_up(r_s2_b, r_s2_hh);
            lqpi_pkg::QP_F:  n_o_pix = lqpi_pkg::avg_up(r_s2_b, r_s2_j);
            lqpi_pkg::QP_G2: n_o_pix = lqpi_pkg::avg_up(r_s2_b, r_s2_mm);
            lqpi_pkg::QP_H:  n_o_pix = r_s2_hh;
            lqpi_pkg::QP_I:  n_o_pix = lqpi_pkg::avg_up(r_s2_hh, r_s2_j);
            lqpi_pkg::QP_J:  n_o_pix = r_s2_j;
            lqpi_pkg::QP_K:  n_o_pix = lqpi_pkg::avg_up(r_s2_mm, r_s2_j);
            lqpi_pkg::QP_N:  n_o_pix = lqpi_pkg::avg_up(r_s2_m, r_s2_hh);
            lqpi_pkg::QP_P:  n_o_pix = lqpi_pkg::avg_up(r_s2_hh, r_s2_s);
            lqpi_pkg::QP_Q:  n_o_pix = lqpi_pkg::avg_up(r_s2_s, r_s2_j);
            default:         n_o_pix = lqpi_pkg::avg_up(r_s2_mm, r_s2_s);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_pix  <= n_o_pix;
            r_o_last <= r_s2_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_pred_pixel = r_o_pix;
    assign o_block_end  = r_o_last;

endmodule
`default_nettype wire

// ===== rtl/luma_quarter_pel_interpolator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// luma_quarter_pel_interpolator
// Six-tap quarter-pel luma interpolation over a streamed reference window.
//
//   channel  direction  handshake                     payload
//   ref      in         i_ref_valid / o_ref_stall     i_ref_pixel
//   pred     out        o_pred_valid / i_pred_stall   o_pred_pixel, o_block_end
//   cfg      in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One reference pixel per cycle while o_ref_stall is low; each pixel that
// completes a window gives a predicted pixel on the output after the line
// store read at its accept, the window word in the queue and three filter stages.
// The five line stores have one read and one write port each at the column.
// Reset is synchronous; the line stores are not cleared.
// A full two-entry queue stalls the front; a stalled output only stalls back.
// ----------------------------------------------------------------------------
module luma_quarter_pel_interpolator #(
    parameter int MAX_BLOCK_WIDTH  = 16,
    parameter int MAX_BLOCK_HEIGHT = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_ref_valid,
    output logic            o_ref_stall,
    input  wire logic [7:0] i_ref_pixel,
    output logic            o_pred_valid,
    input  wire logic       i_pred_stall,
    output logic [7:0]      o_pred_pixel,
    output logic            o_block_end,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [4:0] i_cfg_data
);

    logic [1:0]       r_frac_x;
    logic [1:0]       r_frac_y;
    logic [4:0]       r_width;
    logic [4:0]       r_height;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    lqpi_pkg::t_qword q_in;
    lqpi_pkg::t_qword q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_x <= 2'd0;
            r_frac_y <= 2'd0;
            r_width  <= 5'd16;
            r_height <= 5'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lqpi_pkg::CFG_FRAC_X:      r_frac_x <= i_cfg_data[1:0];
                lqpi_pkg::CFG_FRAC_Y:      r_frac_y <= i_cfg_data[1:0];
                lqpi_pkg::CFG_BLOCK_WIDTH: r_width  <= i_cfg_data;
                default:                   r_height <= i_cfg_data;
            endcase
        end
    end

    lqpi_front #(
        .MAX_BLOCK_WIDTH  (MAX_BLOCK_WIDTH),
        .MAX_BLOCK_HEIGHT (MAX_BLOCK_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_ref_valid),
        .o_stall        (o_ref_stall),
        .i_ref_pixel    (i_ref_pixel),
        .i_restart      (i_cfg_we),
        .i_block_width  (r_width),
        .i_block_height (r_height),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_word       (q_in)
    );

    lqpi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_word  (q_out)
    );

    lqpi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frac_x     (r_frac_x),
        .i_frac_y     (r_frac_y),
        .i_q_empty    (q_empty),
        .i_q_word     (q_out),
        .o_q_pop      (q_pop),
        .o_valid      (o_pred_valid),
        .i_stall      (i_pred_stall),
        .o_pred_pixel (o_pred_pixel),
        .o_block_end  (o_block_end)
    );

endmodule
`default_nettype wire

// ===== rtl/lqpi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lqpi_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module lqpi_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_ref_stall,
    input wire logic       o_pred_valid,
    input wire logic       i_pred_stall,
    input wire logic [7:0] o_pred_pixel,
    input wire logic       o_block_end
);

    // hold a stalled output word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pred_valid && i_pred_stall |=> o_pred_valid
            && $stable(o_pred_pixel) && $stable(o_block_end))
        else $error("stalled output word changed");

    // drop everything on reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pred_valid)
        else $error("output valid after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ref_stall)
        else $error("input stalled after reset");

endmodule

bind luma_quarter_pel_interpolator lqpi_checker u_lqpi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ref_stall  (o_ref_stall),
    .o_pred_valid (o_pred_valid),
    .i_pred_stall (i_pred_stall),
    .o_pred_pixel (o_pred_pixel),
    .o_block_end  (o_block_end)
);
`default_nettype wire
